// ===== hdl/rss_pkg.sv =====
// Shared constants, codes and types for the revoked serial set.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package rss_pkg;

   localparam int ENTRIES   = 64;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int SERIAL_W  = 64;
   localparam int TIME_W    = 64;
   localparam int ACTION_W  = 2;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;

   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REVOKED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

   typedef struct packed {
      logic cmp_en;
      logic add_en;
      logic rem_en;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== hdl/rss_if.sv =====
// Handshake channel interfaces for requests, responses and the register write.
// Depends on rss_pkg for the field widths.
`default_nettype none
interface rss_req_if import rss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SERIAL_W-1:0] serial;
   logic [TIME_W-1:0]   now_time;
   modport source (output valid, action, serial, now_time, input ready);
   modport sink   (input valid, action, serial, now_time, output ready);
endinterface

interface rss_rsp_if import rss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                origin;
   logic                error;
   logic [COUNT_W-1:0]  entry_count;
   modport source (output valid, status, origin, error, entry_count, input ready);
   modport sink   (input valid, status, origin, error, entry_count, output ready);
endinterface

interface rss_csr_if import rss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] expire_time;
   modport source (output valid, expire_time, input ready);
   modport sink   (input valid, expire_time, output ready);
endinterface
`default_nettype wire

// ===== hdl/rss_cell.sv =====
// One storage cell of the serial chain: holds one entry, compares it and shifts.
// Depends on rss_pkg; instantiated in a row by revoked_serial_set_unit.
`default_nettype none
module rss_cell import rss_pkg::*; (
   input  wire logic                clock,
   input  wire cell_ctl_type        ctl,
   input  wire logic [SERIAL_W-1:0] serial,
   input  wire logic                live,
   input  wire logic                add_here,
   input  wire logic [SERIAL_W-1:0] next_entry,
   input  wire logic                shift_in,
   output logic                     shift_out,
   output logic                     hit,
   output logic [SERIAL_W-1:0]      entry
);

   logic [SERIAL_W-1:0] entry_ff, entry_in;
   logic                hit_ff, hit_in;

   // A cell moves its upper neighbor down once the match lies at or below it.
   assign shift_out = shift_in | hit_ff;
   assign hit       = hit_ff;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      if (ctl.cmp_en) begin
         hit_in = live && (entry_ff == serial);
      end
      if (ctl.rem_en && shift_out) begin
         entry_in = next_entry;
      end else if (ctl.add_en && add_here) begin
         entry_in = serial;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

endmodule
`default_nettype wire

// ===== hdl/revoked_serial_set_unit.sv =====
// Top level of the revoked serial set: control sequencer and a row of rss_cell.
// Depends on rss_pkg, the interfaces in rss_if.sv and rss_cell.
// A request is registered, compared across all cells in the compare state, then applied
// in the update state, which shifts or appends along the chain and registers the response.
// The update waits until an earlier response is taken; the next request is accepted then.
// Reset clears the count, the expiry limit and the control state; the set starts empty.
`default_nettype none
module revoked_serial_set_unit import rss_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rss_req_if.sink   req,
   rss_rsp_if.source rsp,
   rss_csr_if.sink   csr
);

   typedef enum logic [2:0] {
      IDLE = 3'b001,
      CMP  = 3'b010,
      UPD  = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [ACTION_W-1:0] action_ff;
   logic [SERIAL_W-1:0] serial_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [TIME_W-1:0]   expire_time_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                expired_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                source_ff, source_in;
   logic                error_ff, error_in;

   logic                upd_go;
   logic                accept;
   logic                found;
   cell_ctl_type        ctl;
   logic [ENTRIES-1:0]  hit_vec;
   logic [ENTRIES-1:0]  live_vec;
   logic [ENTRIES-1:0]  add_vec;
   logic [ENTRIES:0]    shift_vec;
   logic [SERIAL_W-1:0] entry_vec [ENTRIES];

   assign upd_go    = (state_ff == UPD) && (!rsp_valid_ff || rsp.ready);
   assign req.ready = (state_ff == IDLE) || upd_go;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign found     = |hit_vec;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.origin      = source_ff;
   assign rsp.error       = error_ff;
   assign rsp.entry_count = COUNT_W'(count_ff);

   always_comb begin
      ctl.cmp_en = (state_ff == CMP);
      ctl.add_en = 1'b0;
      ctl.rem_en = 1'b0;
      count_in   = count_ff;
      status_in  = ST_GOOD;
      source_in  = 1'b0;
      error_in   = 1'b0;
      unique case (action_ff)
         ACT_QUERY: begin
            if (expired_ff) begin
               status_in = ST_UNKNOWN;
            end else begin
               status_in = found ? ST_REVOKED : ST_GOOD;
               source_in = 1'b1;
            end
         end
         ACT_ADD: begin
            if (!found) begin
               if (count_ff == CNT_W'(ENTRIES)) begin
                  error_in = 1'b1;
               end else begin
                  ctl.add_en = upd_go;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
         end
         ACT_REMOVE: begin
            if (found) begin
               ctl.rem_en = upd_go;
               count_in   = count_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: if (accept) state_in = CMP;
         CMP:  state_in = UPD;
         UPD: begin
            if (upd_go) state_in = accept ? CMP : IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   assign shift_vec[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      assign live_vec[i] = CNT_W'(i) < count_ff;
      assign add_vec[i]  = CNT_W'(i) == count_ff;
      rss_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .serial     (serial_ff),
         .live       (live_vec[i]),
         .add_here   (add_vec[i]),
         .next_entry (entry_vec[(i + 1 < ENTRIES) ? i + 1 : i]),
         .shift_in   (shift_vec[i]),
         .shift_out  (shift_vec[i+1]),
         .hit        (hit_vec[i]),
         .entry      (entry_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         count_ff       <= '0;
         expire_time_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready) begin
            expire_time_ff <= csr.expire_time;
         end
         if (upd_go) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req.action;
         serial_ff <= req.serial;
         now_ff    <= req.now_time;
      end
      if (state_ff == CMP) begin
         expired_ff <= now_ff > expire_time_ff;
      end
      if (upd_go) begin
         status_ff <= status_in;
         source_ff <= source_in;
         error_ff  <= error_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count exceeds capacity");

   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == UPD) |-> $onehot0(hit_vec))
      else $error("serial matched in more than one cell");

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == UPD))
      else $error("response raised without an update cycle");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(upd_go) |-> $stable(count_ff))
      else $error("entry count changed outside an update");

endmodule
`default_nettype wire
